FILE: rtl/core/scp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scp_pkg;

   // Field and datapath widths.
   localparam int POS_W       = 24;
   localparam int VEC_W       = 16;
   localparam int DIFF_W      = 25;
   localparam int PROD_W      = 41;
   localparam int PLANE_W     = 32;
   localparam int NUM_W       = 42;
   localparam int SUMC_W      = 43;
   localparam int DEN_W       = 33;
   localparam int DEPTH_SHIFT = 14;
   localparam int DEP_NUM_W   = NUM_W + DEPTH_SHIFT;
   localparam int DEPTH_W     = 26;
   localparam int DQ_BITS     = 26;
   localparam int HQ_BITS     = 16;
   localparam int HEIGHT_FRAC = 16;
   localparam int CENTER_W    = 16;
   localparam int CMAG_W      = 15;
   localparam int HEIGHT_W    = 13;
   localparam int SHADE_W     = 8;
   localparam int XS_W        = 11;
   localparam int XE_W        = 11;
   localparam int YS_W        = 9;
   localparam int YE_W        = 10;
   localparam int CSR_IDX_W   = 3;
   localparam int FRONT_STAGES = 5;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_PLAYER_X       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAYER_Y       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_DIR_X     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_DIR_Y     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_PLANE_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_PLANE_Y = 3'd5;

   localparam logic signed [VEC_W-1:0] VIEW_DIR_X_RST     = -16'sd16384;
   localparam logic signed [VEC_W-1:0] CAMERA_PLANE_Y_RST = 16'sd10813;

   localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 26'sh1FFFFFF;
   localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 26'sh2000000;
   localparam logic signed [DEPTH_W-1:0] DEPTH_VIS = 26'sd6553;
   localparam logic [HEIGHT_W-1:0]       HEIGHT_MAX = 13'd8191;
   localparam logic [CMAG_W-1:0]         CENTER_LIM = 15'h4000;

   typedef struct packed {
      logic den_zero;
      logic depth_neg;
      logic center_neg;
   } front_flags_type;

   typedef struct packed {
      logic signed [DEPTH_W-1:0]  depth;
      logic signed [CENTER_W-1:0] center;
      logic                       visible;
      logic                       den_zero;
   } back_side_type;

endpackage

`default_nettype wire

FILE: rtl/core/scp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface scp_req_if;
   logic                        valid;
   logic                        ready;
   logic [scp_pkg::POS_W-1:0]   sprite_x;
   logic [scp_pkg::POS_W-1:0]   sprite_y;

   modport source (output valid, output sprite_x, output sprite_y, input ready);
   modport sink   (input valid, input sprite_x, input sprite_y, output ready);
endinterface

interface scp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               visible;
   logic signed [scp_pkg::DEPTH_W-1:0] depth;
   logic [scp_pkg::SHADE_W-1:0]        shade_index;
   logic [scp_pkg::HEIGHT_W-1:0]       sprite_height;
   logic [scp_pkg::XS_W-1:0]           x_start;
   logic signed [scp_pkg::XE_W-1:0]    x_end;
   logic [scp_pkg::YS_W-1:0]           y_start;
   logic [scp_pkg::YE_W-1:0]           y_end;

   modport source (output valid, output visible, output depth, output shade_index,
                   output sprite_height, output x_start, output x_end, output y_start,
                   output y_end, input ready);
   modport sink   (input valid, input visible, input depth, input shade_index,
                   input sprite_height, input x_start, input x_end, input y_start,
                   input y_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/scp_ctl.sv
`timescale 1ns / 1ps
`default_nettype none

module scp_ctl #(
   parameter int STAGES = 51
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [STAGES-1:0] en
);

   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] v_in;

   // A stage loads when it is empty or when the stage after it loads.
   always_comb begin
      en[STAGES-1] = ~v_ff[STAGES-1] | out_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         en[i] = ~v_ff[i] | en[i+1];
      end
   end

   assign v_in      = {v_ff[STAGES-2:0], in_valid};
   assign in_ready  = en[0];
   assign out_valid = v_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/scp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module scp_front #(
   parameter int SCREEN_WIDTH = 1024,
   parameter int CN_W = scp_pkg::SUMC_W + $clog2(SCREEN_WIDTH / 2 + 1)
) (
   input  logic                                  clock,
   input  logic [scp_pkg::FRONT_STAGES-1:0]      en,
   input  logic [scp_pkg::POS_W-1:0]             sprite_x,
   input  logic [scp_pkg::POS_W-1:0]             sprite_y,
   input  logic [scp_pkg::POS_W-1:0]             player_x,
   input  logic [scp_pkg::POS_W-1:0]             player_y,
   input  logic signed [scp_pkg::VEC_W-1:0]      dir_x,
   input  logic signed [scp_pkg::VEC_W-1:0]      dir_y,
   input  logic signed [scp_pkg::VEC_W-1:0]      plane_x,
   input  logic signed [scp_pkg::VEC_W-1:0]      plane_y,
   output logic [scp_pkg::DEP_NUM_W-1:0]         dep_num,
   output logic [scp_pkg::DEN_W-1:0]             dep_den,
   output logic [CN_W-1:0]                       cen_num,
   output logic [scp_pkg::NUM_W-1:0]             cen_den,
   output scp_pkg::front_flags_type              flags
);
   import scp_pkg::*;

   localparam int HALF_W = SCREEN_WIDTH / 2;

   logic signed [DIFF_W-1:0]  s0_ff, s1_ff;
   logic signed [PROD_W-1:0]  dys0_ff, dxs1_ff, pys0_ff, pxs1_ff;
   logic signed [PLANE_W-1:0] pxdy_ff, dxpy_ff;
   logic signed [NUM_W-1:0]   num0_ff, num1_ff;
   logic signed [SUMC_W-1:0]  sumc_ff;
   logic signed [DEN_W-1:0]   den_ff;
   logic [NUM_W-1:0]          an1_ff;
   logic [DEN_W-1:0]          aden_ff;
   logic [SUMC_W-1:0]         asum_ff;
   front_flags_type           flags3_ff, flags4_ff;
   logic [DEP_NUM_W-1:0]      dep_num_ff;
   logic [DEN_W-1:0]          dep_den_ff;
   logic [CN_W-1:0]           cen_num_ff;
   logic [NUM_W-1:0]          cen_den_ff;

   // Sprite position relative to the player.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_ff <= $signed({1'b0, sprite_x}) - $signed({1'b0, player_x});
         s1_ff <= $signed({1'b0, sprite_y}) - $signed({1'b0, player_y});
      end
   end

   // Products of the inverse camera matrix.
   always_ff @(posedge clock) begin
      if (en[1]) begin
         dys0_ff <= dir_y * s0_ff;
         dxs1_ff <= dir_x * s1_ff;
         pys0_ff <= plane_y * s0_ff;
         pxs1_ff <= plane_x * s1_ff;
         pxdy_ff <= plane_x * dir_y;
         dxpy_ff <= dir_x * plane_y;
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         num0_ff <= NUM_W'(dys0_ff) - NUM_W'(dxs1_ff);
         num1_ff <= NUM_W'(pxs1_ff) - NUM_W'(pys0_ff);
         sumc_ff <= SUMC_W'(dys0_ff) - SUMC_W'(dxs1_ff) + SUMC_W'(pxs1_ff)
                    - SUMC_W'(pys0_ff);
         den_ff  <= DEN_W'(pxdy_ff) - DEN_W'(dxpy_ff);
      end
   end

   // Both divisions run on magnitudes; the signs travel alongside.
   always_ff @(posedge clock) begin
      if (en[3]) begin
         an1_ff  <= $unsigned(num1_ff[NUM_W-1] ? -num1_ff : num1_ff);
         aden_ff <= $unsigned(den_ff[DEN_W-1] ? -den_ff : den_ff);
         asum_ff <= $unsigned(sumc_ff[SUMC_W-1] ? -sumc_ff : sumc_ff);
         flags3_ff.den_zero   <= (den_ff == '0);
         flags3_ff.depth_neg  <= num1_ff[NUM_W-1] ^ den_ff[DEN_W-1];
         flags3_ff.center_neg <= sumc_ff[SUMC_W-1] ^ num1_ff[NUM_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         dep_num_ff <= {an1_ff, {DEPTH_SHIFT{1'b0}}};
         dep_den_ff <= aden_ff;
         cen_num_ff <= CN_W'(asum_ff) * CN_W'(HALF_W);
         cen_den_ff <= an1_ff;
         flags4_ff  <= flags3_ff;
      end
   end

   assign dep_num = dep_num_ff;
   assign dep_den = dep_den_ff;
   assign cen_num = cen_num_ff;
   assign cen_den = cen_den_ff;
   assign flags   = flags4_ff;

endmodule

`default_nettype wire

FILE: rtl/core/scp_div.sv
`timescale 1ns / 1ps
`default_nettype none

module scp_div #(
   parameter int NW = 56,
   parameter int DW = 33,
   parameter int QB = 26,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic [QB:0]   en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [SW-1:0] side,
   output logic [QB-1:0] quo,
   output logic          ovf,
   output logic [SW-1:0] side_out
);

   localparam int RW = ((NW > DW + QB) ? NW : DW + QB) + 1;

   logic [RW-1:0] rem_ff [QB+1];
   logic [DW-1:0] dv_ff  [QB+1];
   logic [QB-1:0] q_ff   [QB+1];
   logic          ovf_ff [QB+1];
   logic [SW-1:0] sd_ff  [QB+1];
   logic [RW-1:0] lim_w;
   logic [RW-1:0] sub_w  [1:QB];
   logic [RW:0]   diff_w [1:QB];

   assign lim_w = RW'(den) << QB;

   // One quotient bit per stage, most significant first.
   always_comb begin
      for (int i = 1; i <= QB; i++) begin
         sub_w[i]  = RW'(dv_ff[i-1]) << (QB - i);
         diff_w[i] = {1'b0, rem_ff[i-1]} - {1'b0, sub_w[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0] <= RW'(num);
         dv_ff[0]  <= den;
         q_ff[0]   <= '0;
         ovf_ff[0] <= (RW'(num) >= lim_w);
         sd_ff[0]  <= side;
      end
      for (int i = 1; i <= QB; i++) begin
         if (en[i]) begin
            rem_ff[i] <= diff_w[i][RW] ? rem_ff[i-1] : diff_w[i][RW-1:0];
            dv_ff[i]  <= dv_ff[i-1];
            q_ff[i]   <= {q_ff[i-1][QB-2:0], ~diff_w[i][RW]};
            ovf_ff[i] <= ovf_ff[i-1];
            sd_ff[i]  <= sd_ff[i-1];
         end
      end
   end

   assign quo      = q_ff[QB];
   assign ovf      = ovf_ff[QB];
   assign side_out = sd_ff[QB];

endmodule

`default_nettype wire

FILE: rtl/core/scp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module scp_back #(
   parameter int SCREEN_WIDTH  = 1024,
   parameter int SCREEN_HEIGHT = 768,
   parameter int SHADE_STEPS   = 256
) (
   input  logic                                 clock,
   input  logic [scp_pkg::HQ_BITS+2:0]          en,
   input  logic [scp_pkg::DQ_BITS-1:0]          dep_quo,
   input  logic                                 dep_ovf,
   input  logic [scp_pkg::DQ_BITS-1:0]          cen_quo,
   input  logic                                 cen_ovf,
   input  scp_pkg::front_flags_type             flags,
   output logic                                 visible,
   output logic signed [scp_pkg::DEPTH_W-1:0]   depth,
   output logic [scp_pkg::SHADE_W-1:0]          shade_index,
   output logic [scp_pkg::HEIGHT_W-1:0]         sprite_height,
   output logic [scp_pkg::XS_W-1:0]             x_start,
   output logic signed [scp_pkg::XE_W-1:0]      x_end,
   output logic [scp_pkg::YS_W-1:0]             y_start,
   output logic [scp_pkg::YE_W-1:0]             y_end
);
   import scp_pkg::*;

   localparam int HN_W      = $clog2(SCREEN_HEIGHT + 1) + HEIGHT_FRAC;
   localparam int HALF_H    = SCREEN_HEIGHT / 2;
   localparam int SHADE_TOP = (SHADE_STEPS - 1 < 255) ? SHADE_STEPS - 1 : 255;
   localparam int XS_TOP    = (SCREEN_WIDTH < 2047) ? SCREEN_WIDTH : 2047;
   localparam int XE_TOP    = (SCREEN_WIDTH - 1 < 1023) ? SCREEN_WIDTH - 1 : 1023;
   localparam int YS_TOP    = 511;
   localparam int YE_TOP    = (SCREEN_HEIGHT - 1 < 1023) ? SCREEN_HEIGHT - 1 : 1023;
   localparam int SIDE_W    = $bits(back_side_type);

   logic signed [DEPTH_W-1:0]  dep_w;
   logic [CMAG_W-1:0]          cmag_w;
   logic signed [CENTER_W-1:0] cen_w;
   back_side_type              mid_ff;
   back_side_type              mid_w;
   back_side_type              hsd;
   logic [HQ_BITS-1:0]         hq;
   logic                       hovf;
   logic [HN_W-1:0]            hnum;

   // Sign and saturate the depth quotient, limit and sign the column center, set the visible flag.
   always_comb begin
      if (!flags.depth_neg) begin
         dep_w = (dep_ovf || dep_quo[DQ_BITS-1]) ? DEPTH_MAX : $signed(dep_quo);
      end else if (dep_ovf || (dep_quo[DQ_BITS-1] && (|dep_quo[DQ_BITS-2:0]))) begin
         dep_w = DEPTH_MIN;
      end else begin
         dep_w = -$signed(dep_quo);
      end
      cmag_w = (cen_ovf || (cen_quo >= DQ_BITS'(CENTER_LIM))) ? CENTER_LIM
               : cen_quo[CMAG_W-1:0];
      cen_w  = flags.center_neg ? -$signed({1'b0, cmag_w}) : $signed({1'b0, cmag_w});
      mid_w.depth    = dep_w;
      mid_w.center   = cen_w;
      mid_w.den_zero = flags.den_zero;
      mid_w.visible  = !flags.den_zero && (dep_w > DEPTH_VIS);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mid_ff <= mid_w;
      end
   end

   // Height is screen height over depth; the numerator is a constant.
   assign hnum = HN_W'(SCREEN_HEIGHT) << HEIGHT_FRAC;

   scp_div #(
      .NW (HN_W),
      .DW (DEPTH_W - 1),
      .QB (HQ_BITS),
      .SW (SIDE_W)
   ) u_hdiv (
      .clock    (clock),
      .en       (en[HQ_BITS+1:1]),
      .num      (hnum),
      .den      ($unsigned(mid_ff.depth[DEPTH_W-2:0])),
      .side     (mid_ff),
      .quo      (hq),
      .ovf      (hovf),
      .side_out (hsd)
   );

   logic [HEIGHT_W-1:0]     h_w;
   logic [HEIGHT_W-2:0]     hh_w;
   logic [28:0]             prod_w;
   logic [12:0]             sh_w;
   logic signed [16:0]      cen17_w, hh17_w, xs_w, xe_w;
   logic signed [14:0]      ys_w;
   logic [13:0]             ye_w;
   logic [SHADE_W-1:0]      shade_in;
   logic [XS_W-1:0]         xs_in;
   logic signed [XE_W-1:0]  xe_in;
   logic [YS_W-1:0]         ys_in;
   logic [YE_W-1:0]         ye_in;

   logic                       vis_ff;
   logic signed [DEPTH_W-1:0]  depth_ff;
   logic [SHADE_W-1:0]         shade_ff;
   logic [HEIGHT_W-1:0]        height_ff;
   logic [XS_W-1:0]            xs_ff;
   logic signed [XE_W-1:0]     xe_ff;
   logic [YS_W-1:0]            ys_ff;
   logic [YE_W-1:0]            ye_ff;

   always_comb begin
      h_w     = (hovf || (hq > HQ_BITS'(HEIGHT_MAX))) ? HEIGHT_MAX : hq[HEIGHT_W-1:0];
      hh_w    = h_w[HEIGHT_W-1:1];
      prod_w  = 29'(hsd.depth[DEPTH_W-2:0]) * 29'd10;
      sh_w    = prod_w[28:16];
      shade_in = (sh_w > 13'(SHADE_TOP)) ? SHADE_W'(SHADE_TOP) : sh_w[SHADE_W-1:0];

      cen17_w = 17'(hsd.center);
      hh17_w  = $signed({5'b0, hh_w});
      xs_w    = cen17_w - hh17_w;
      xe_w    = cen17_w + hh17_w;
      if (xs_w < 0) begin
         xs_in = '0;
      end else if (xs_w > 17'(XS_TOP)) begin
         xs_in = XS_W'(XS_TOP);
      end else begin
         xs_in = xs_w[XS_W-1:0];
      end
      if (xe_w < -17'sd1) begin
         xe_in = -11'sd1;
      end else if (xe_w > 17'(XE_TOP)) begin
         xe_in = XE_W'(XE_TOP);
      end else begin
         xe_in = xe_w[XE_W-1:0];
      end

      ys_w = 15'(HALF_H) - $signed({3'b0, hh_w});
      if (ys_w < 0) begin
         ys_in = '0;
      end else if (ys_w > 15'(YS_TOP)) begin
         ys_in = YS_W'(YS_TOP);
      end else begin
         ys_in = ys_w[YS_W-1:0];
      end
      ye_w  = 14'(HALF_H) + 14'(hh_w);
      ye_in = (ye_w > 14'(YE_TOP)) ? YE_W'(YE_TOP) : ye_w[YE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[HQ_BITS+2]) begin
         vis_ff    <= hsd.visible;
         depth_ff  <= hsd.den_zero ? '0 : hsd.depth;
         shade_ff  <= hsd.visible ? shade_in : '0;
         height_ff <= hsd.visible ? h_w : '0;
         xs_ff     <= hsd.visible ? xs_in : '0;
         xe_ff     <= hsd.visible ? xe_in : '0;
         ys_ff     <= hsd.visible ? ys_in : '0;
         ye_ff     <= hsd.visible ? ye_in : '0;
      end
   end

   assign visible       = vis_ff;
   assign depth         = depth_ff;
   assign shade_index   = shade_ff;
   assign sprite_height = height_ff;
   assign x_start       = xs_ff;
   assign x_end         = xe_ff;
   assign y_start       = ys_ff;
   assign y_end         = ye_ff;

endmodule

`default_nettype wire

FILE: rtl/core/sprite_camera_projection_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Sprite camera projection core.
// Each item on req_chan carries one sprite position (unsigned Q8.16). The core
// subtracts the player position, applies the inverse camera matrix and returns
// one item on rsp_chan with the camera-space depth (signed Q9.16, saturated),
// the visible flag, the shade index and the clipped screen spans.
// The csr_ port writes the player position, view direction and camera plane;
// write it only while no item is in flight.
// The core is a 51-stage pipeline: five stages form the products and
// magnitudes, two restoring dividers (depth and screen column) load their
// operands and then retire one quotient bit per stage, 27 stages in lockstep,
// one stage signs and saturates, a height divider takes 17 stages and a last
// stage clips and holds the result. A new item is accepted in every cycle
// unless every stage holds an item and the receiver stalls.
// Reset clears the stage valid bits and loads the default camera.
// When the receiver stalls, the result holds in the output stage and the
// stages behind it keep filling their empty slots; req ready drops only once
// every stage holds an item.
module sprite_camera_projection_core #(
   parameter int SCREEN_WIDTH  = 1024,
   parameter int SCREEN_HEIGHT = 768,
   parameter int SHADE_STEPS   = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   scp_req_if.sink                           req_chan,
   scp_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [scp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [scp_pkg::POS_W-1:0]         csr_wdata
);
   import scp_pkg::*;

   localparam int CN_W   = SUMC_W + $clog2(SCREEN_WIDTH / 2 + 1);
   localparam int DIV0   = FRONT_STAGES;
   localparam int BACK0  = DIV0 + DQ_BITS + 1;
   localparam int STAGES = BACK0 + HQ_BITS + 3;

   logic [POS_W-1:0]        player_x_ff, player_y_ff;
   logic signed [VEC_W-1:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;

   // Camera registers; an index past the last register is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         player_x_ff <= '0;
         player_y_ff <= '0;
         dir_x_ff    <= VIEW_DIR_X_RST;
         dir_y_ff    <= '0;
         plane_x_ff  <= '0;
         plane_y_ff  <= CAMERA_PLANE_Y_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PLAYER_X:       player_x_ff <= csr_wdata;
            CSR_PLAYER_Y:       player_y_ff <= csr_wdata;
            CSR_VIEW_DIR_X:     dir_x_ff    <= $signed(csr_wdata[VEC_W-1:0]);
            CSR_VIEW_DIR_Y:     dir_y_ff    <= $signed(csr_wdata[VEC_W-1:0]);
            CSR_CAMERA_PLANE_X: plane_x_ff  <= $signed(csr_wdata[VEC_W-1:0]);
            CSR_CAMERA_PLANE_Y: plane_y_ff  <= $signed(csr_wdata[VEC_W-1:0]);
            default: ;
         endcase
      end
   end

   logic [STAGES-1:0] en;

   scp_ctl #(
      .STAGES (STAGES)
   ) u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .en        (en)
   );

   logic [DEP_NUM_W-1:0] dep_num;
   logic [DEN_W-1:0]     dep_den;
   logic [CN_W-1:0]      cen_num;
   logic [NUM_W-1:0]     cen_den;
   front_flags_type      front_flags, div_flags;

   scp_front #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .CN_W         (CN_W)
   ) u_front (
      .clock    (clock),
      .en       (en[FRONT_STAGES-1:0]),
      .sprite_x (req_chan.sprite_x),
      .sprite_y (req_chan.sprite_y),
      .player_x (player_x_ff),
      .player_y (player_y_ff),
      .dir_x    (dir_x_ff),
      .dir_y    (dir_y_ff),
      .plane_x  (plane_x_ff),
      .plane_y  (plane_y_ff),
      .dep_num  (dep_num),
      .dep_den  (dep_den),
      .cen_num  (cen_num),
      .cen_den  (cen_den),
      .flags    (front_flags)
   );

   logic [DQ_BITS-1:0] dep_quo, cen_quo;
   logic               dep_ovf, cen_ovf;

   // Depth and screen column are divided side by side, stage for stage;
   // the sign flags ride along with the depth divider.
   scp_div #(
      .NW (DEP_NUM_W),
      .DW (DEN_W),
      .QB (DQ_BITS),
      .SW ($bits(front_flags_type))
   ) u_ddiv (
      .clock    (clock),
      .en       (en[BACK0-1:DIV0]),
      .num      (dep_num),
      .den      (dep_den),
      .side     (front_flags),
      .quo      (dep_quo),
      .ovf      (dep_ovf),
      .side_out (div_flags)
   );

   logic cen_side;

   scp_div #(
      .NW (CN_W),
      .DW (NUM_W),
      .QB (DQ_BITS),
      .SW (1)
   ) u_cdiv (
      .clock    (clock),
      .en       (en[BACK0-1:DIV0]),
      .num      (cen_num),
      .den      (cen_den),
      .side     (front_flags.den_zero),
      .quo      (cen_quo),
      .ovf      (cen_ovf),
      .side_out (cen_side)
   );

   front_flags_type back_flags;

   always_comb begin
      back_flags          = div_flags;
      back_flags.den_zero = cen_side;
   end

   scp_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .SHADE_STEPS   (SHADE_STEPS)
   ) u_back (
      .clock         (clock),
      .en            (en[STAGES-1:BACK0]),
      .dep_quo       (dep_quo),
      .dep_ovf       (dep_ovf),
      .cen_quo       (cen_quo),
      .cen_ovf       (cen_ovf),
      .flags         (back_flags),
      .visible       (rsp_chan.visible),
      .depth         (rsp_chan.depth),
      .shade_index   (rsp_chan.shade_index),
      .sprite_height (rsp_chan.sprite_height),
      .x_start       (rsp_chan.x_start),
      .x_end         (rsp_chan.x_end),
      .y_start       (rsp_chan.y_start),
      .y_end         (rsp_chan.y_end)
   );

endmodule

`default_nettype wire
